@@ sv/shs_pkg.sv @@
package shs_pkg;

  localparam int DATA_W    = 32;
  localparam int GAP_COUNT = 5;
  localparam int GIDX_W    = 3;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_INIT,
    ST_PICK,
    ST_GETV,
    ST_CMP,
    ST_PUT,
    ST_OREAD,
    ST_OWAIT,
    ST_OSEND
  } state_t;

  // Knuth gap sequence h = 3h + 1, smallest first.
  function automatic int unsigned gap_of(input logic [GIDX_W-1:0] idx);
    int unsigned g;
    case (idx)
      3'd0: g = 1;
      3'd1: g = 4;
      3'd2: g = 13;
      3'd3: g = 40;
      3'd4: g = 121;
      default: g = 1;
    endcase
    return g;
  endfunction

endpackage

@@ sv/shellsort_batch_sorter_top.sv @@
// Channel  Direction  Payload
// s_*      in         tdata = sample (signed), tlast = final_item
// m_*      out        tdata = sorted_value (signed), tlast = end_of_run,
//                     tuser = overflowed
//
// Loading takes one value per cycle until the transaction with tlast set.
// Sorting runs Shellsort over the one-read, one-write store: each insertion reads
// its value, moves larger entries down its gap chain with one compare per cycle,
// then writes the value, with no final compare when it reaches the chain's front.
// Each result is read from the store and registered before it is offered on m_*; the next read starts once it is taken.
// Reset is synchronous and empties the store; no input is taken while sorting
// or sending, and a stalled result holds until it is taken.
module shellsort_batch_sorter_top #(
  parameter int STORE_DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [shs_pkg::DATA_W-1:0] s_tdata,   // [31:0] sample
  input  logic                       s_tlast,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [shs_pkg::DATA_W-1:0] m_tdata,   // [31:0] sorted_value
  output logic                       m_tlast,
  output logic                       m_tuser    // [0] overflowed
);
  import shs_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = $clog2(STORE_DEPTH + 1);

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic [AW-1:0]     rd_addr;
  logic [DATA_W-1:0] rd_data;

  shs_seq #(
    .STORE_DEPTH(STORE_DEPTH),
    .AW         (AW),
    .CW         (CW)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  shs_store #(
    .STORE_DEPTH(STORE_DEPTH),
    .AW         (AW)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  a_phase_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input and output phases overlap");

  a_final_stops_input: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input still taken after the final transaction");

  a_last_reopens: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
    else $error("block not back to loading after the last result");

endmodule

@@ sv/shs_store.sv @@
module shs_store #(
  parameter int STORE_DEPTH = 64,
  parameter int AW          = $clog2(STORE_DEPTH)
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [shs_pkg::DATA_W-1:0] wr_data,
  input  logic [AW-1:0]              rd_addr,
  output logic [shs_pkg::DATA_W-1:0] rd_data
);
  import shs_pkg::*;

  logic [DATA_W-1:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

@@ sv/shs_seq.sv @@
module shs_seq #(
  parameter int STORE_DEPTH = 64,
  parameter int AW          = $clog2(STORE_DEPTH),
  parameter int CW          = $clog2(STORE_DEPTH + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [shs_pkg::DATA_W-1:0] s_tdata,
  input  logic                       s_tlast,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [shs_pkg::DATA_W-1:0] m_tdata,
  output logic                       m_tlast,
  output logic                       m_tuser,
  output logic                       wr_en,
  output logic [AW-1:0]              wr_addr,
  output logic [shs_pkg::DATA_W-1:0] wr_data,
  output logic [AW-1:0]              rd_addr,
  input  logic [shs_pkg::DATA_W-1:0] rd_data
);
  import shs_pkg::*;

  state_t            state, state_next;
  logic [CW-1:0]     fill, fill_next;
  logic              ovf, ovf_next;
  logic [GIDX_W-1:0] gidx, gidx_next;
  logic [CW-1:0]     h, h_next;
  logic [CW-1:0]     i, i_next;
  logic [CW-1:0]     j, j_next;
  logic [DATA_W-1:0] v, v_next;
  logic [CW-1:0]     k, k_next;
  logic [DATA_W-1:0] out_data, out_data_next;
  logic              out_last, out_last_next;
  logic              out_ovf, out_ovf_next;

  logic              in_xfer;
  logic              gt;
  logic [CW-1:0]     jn;
  logic [CW-1:0]     jnh;
  logic [CW-1:0]     ih;
  logic [CW-1:0]     i_inc;
  logic [CW-1:0]     k_inc;
  logic [GIDX_W-1:0] gidx_dn;
  logic [GIDX_W-1:0] gidx_start;

  // The data compare: a signed compare of the stored word against the held value.
  assign gt      = $signed(rd_data) > $signed(v);
  assign jn      = j - h;
  assign jnh     = jn - h;
  assign ih      = i - h;
  assign i_inc   = i + 1'b1;
  assign k_inc   = k + 1'b1;
  assign gidx_dn = gidx - 1'b1;
  assign in_xfer = s_tvalid && s_tready;

  // The first gap is the largest one of the sequence below the batch count.
  always_comb begin
    gidx_start = '0;
    for (int g = 1; g < GAP_COUNT; g++) begin
      if (32'(fill) > gap_of(GIDX_W'(g))) begin
        gidx_start = gidx_start + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      fill  <= '0;
      ovf   <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      ovf   <= ovf_next;
    end
  end

  always_ff @(posedge clk) begin
    gidx     <= gidx_next;
    h        <= h_next;
    i        <= i_next;
    j        <= j_next;
    v        <= v_next;
    k        <= k_next;
    out_data <= out_data_next;
    out_last <= out_last_next;
    out_ovf  <= out_ovf_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (in_xfer && s_tlast) begin
          state_next = ST_INIT;
        end
      end
      ST_INIT: begin
        state_next = (fill < CW'(2)) ? ST_OREAD : ST_PICK;
      end
      ST_PICK: state_next = ST_GETV;
      ST_GETV: state_next = ST_CMP;
      ST_CMP: begin
        state_next = (gt && (jn >= h)) ? ST_CMP : ST_PUT;
      end
      ST_PUT: begin
        if (i_inc < fill || gidx != '0) begin
          state_next = ST_PICK;
        end else begin
          state_next = ST_OREAD;
        end
      end
      ST_OREAD: state_next = ST_OWAIT;
      ST_OWAIT: state_next = ST_OSEND;
      ST_OSEND: begin
        if (m_tready) begin
          state_next = out_last ? ST_LOAD : ST_OREAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    fill_next     = fill;
    ovf_next      = ovf;
    gidx_next     = gidx;
    h_next        = h;
    i_next        = i;
    j_next        = j;
    v_next        = v;
    k_next        = k;
    out_data_next = out_data;
    out_last_next = out_last;
    out_ovf_next  = out_ovf;
    wr_en         = 1'b0;
    wr_addr       = j[AW-1:0];
    wr_data       = v;
    rd_addr       = '0;
    s_tready      = (state == ST_LOAD);
    m_tvalid      = (state == ST_OSEND);
    m_tdata       = out_data;
    m_tlast       = out_last;
    m_tuser       = out_ovf;
    case (state)
      ST_LOAD: begin
        if (in_xfer) begin
          if (fill < CW'(STORE_DEPTH)) begin
            wr_en     = 1'b1;
            wr_addr   = fill[AW-1:0];
            wr_data   = s_tdata;
            fill_next = fill + 1'b1;
          end else begin
            ovf_next = 1'b1;
          end
        end
      end
      ST_INIT: begin
        gidx_next = gidx_start;
        h_next    = CW'(gap_of(gidx_start));
        i_next    = CW'(gap_of(gidx_start));
        k_next    = '0;
      end
      ST_PICK: begin
        rd_addr = i[AW-1:0];
      end
      ST_GETV: begin
        v_next  = rd_data;
        j_next  = i;
        rd_addr = ih[AW-1:0];
      end
      ST_CMP: begin
        if (gt) begin
          wr_en   = 1'b1;
          wr_addr = j[AW-1:0];
          wr_data = rd_data;
          j_next  = jn;
          rd_addr = jnh[AW-1:0];
        end
      end
      ST_PUT: begin
        wr_en   = 1'b1;
        wr_addr = j[AW-1:0];
        wr_data = v;
        if (i_inc < fill) begin
          i_next = i_inc;
        end else if (gidx != '0) begin
          gidx_next = gidx_dn;
          h_next    = CW'(gap_of(gidx_dn));
          i_next    = CW'(gap_of(gidx_dn));
        end else begin
          k_next = '0;
        end
      end
      ST_OREAD: begin
        rd_addr = k[AW-1:0];
      end
      ST_OWAIT: begin
        out_data_next = rd_data;
        out_last_next = (k_inc == fill);
        out_ovf_next  = ovf;
      end
      ST_OSEND: begin
        if (m_tready) begin
          if (out_last) begin
            fill_next = '0;
            ovf_next  = 1'b0;
          end else begin
            k_next = k_inc;
          end
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  localparam int DATA_W       = shs_pkg::DATA_W;
  localparam int STORE_DEPTH  = 64;
  localparam int RANDOM_ITEMS = 32;
  localparam int HOLD_CYCLES  = 400;
  localparam int STUCK_LIMIT  = 50000;
  localparam logic [15:0] RX_MASK = 16'b1011_0111_0010_1101;

  typedef enum int {RX_STEADY, RX_COIN, RX_PATTERN, RX_SLOW} rx_mode_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
    logic                     ovf;
  } sorted_word_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata = '0;
  logic              s_tlast = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;
  logic              m_tlast;
  logic              m_tuser;

  logic signed [DATA_W-1:0] batch_vals[$];
  logic                     batch_overflow = 1'b0;
  sorted_word_t             sorted_expect[$];

  int       errors = 0;
  int       stuck_cycles = 0;
  int       tx_gap_max = 0;
  int       tx_burst_left = 0;
  rx_mode_t rx_mode = RX_STEADY;
  int       hold_ticket = 0;
  int       hold_seen = 0;
  int       hold_left = 0;
  logic [3:0] rx_tick = '0;

  shellsort_batch_sorter_top #(
    .STORE_DEPTH(STORE_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // A full store drops further values, the final one included, and flags the batch.
  task automatic note_sample(input logic signed [DATA_W-1:0] value, input logic last);
    logic signed [DATA_W-1:0] vals[$];
    logic signed [DATA_W-1:0] tmp;
    sorted_word_t             word;
    int                       i;
    int                       j;
    if (batch_vals.size() < STORE_DEPTH) batch_vals.push_back(value);
    else batch_overflow = 1'b1;
    if (last) begin
      vals = batch_vals;
      for (i = 1; i < vals.size(); i++) begin
        tmp = vals[i];
        j = i;
        while (j > 0 && vals[j-1] > tmp) begin
          vals[j] = vals[j-1];
          j--;
        end
        vals[j] = tmp;
      end
      for (i = 0; i < vals.size(); i++) begin
        word.value = vals[i];
        word.last  = (i == vals.size() - 1);
        word.ovf   = batch_overflow;
        sorted_expect.push_back(word);
      end
      batch_vals.delete();
      batch_overflow = 1'b0;
    end
  endtask

  task automatic send_sample(input logic signed [DATA_W-1:0] value, input logic last);
    int gap;
    gap = 0;
    if (tx_gap_max > 0) begin
      if (tx_burst_left == 0) begin
        gap = $urandom_range(1, tx_gap_max);
        tx_burst_left = $urandom_range(1, 8);
      end
      tx_burst_left--;
    end
    repeat (gap) @(negedge clk) s_tvalid <= 1'b0;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    note_sample(value, last);
  endtask

  task automatic wait_results_drained();
    @(negedge clk) s_tvalid <= 1'b0;
    while (sorted_expect.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] random_sample();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed(32'($urandom_range(0, 15))) - 8;
      2: return 32'h7fff_fff0 + $urandom_range(0, 15);
      default: return 32'h8000_0000 + $urandom_range(0, 15);
    endcase
  endfunction

  task automatic test_single_item_batches();
    rx_mode = RX_STEADY;
    tx_gap_max = 0;
    send_sample(32'sh7fff_ffff, 1'b1);
    send_sample(32'sh8000_0000, 1'b1);
    send_sample(32'sh0000_0000, 1'b1);
  endtask

  task automatic test_extreme_values();
    rx_mode = RX_COIN;
    tx_gap_max = 3;
    send_sample(32'sh7fff_ffff, 1'b0);
    send_sample(32'sh8000_0000, 1'b1);
    send_sample(32'sh0000_0001, 1'b0);
    send_sample(32'sh8000_0000, 1'b0);
    send_sample(-32'sd1, 1'b0);
    send_sample(32'sh7fff_ffff, 1'b0);
    send_sample(32'sh0000_0000, 1'b0);
    send_sample(-32'sd1, 1'b1);
  endtask

  task automatic test_reverse_order();
    int i;
    rx_mode = RX_PATTERN;
    tx_gap_max = 0;
    for (i = 0; i < 8; i++) send_sample(70 - 10 * i, i == 7);
    wait_results_drained();
  endtask

  task automatic test_store_overflow();
    int i;
    rx_mode = RX_SLOW;
    tx_gap_max = 0;
    for (i = 0; i < STORE_DEPTH + 3; i++) send_sample(random_sample(), i == STORE_DEPTH + 2);
    wait_results_drained();
  endtask

  // The receiver stalls while a second batch is offered, so loading has to wait.
  task automatic test_output_backpressure();
    int i;
    rx_mode = RX_STEADY;
    tx_gap_max = 0;
    hold_ticket++;
    for (i = 0; i < 6; i++) send_sample(random_sample(), i == 5);
    for (i = 0; i < 6; i++) send_sample(random_sample(), i == 5);
    wait_results_drained();
  endtask

  task automatic test_random_batches();
    int sent;
    int batch_len;
    int pick;
    int i;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) batch_len = $urandom_range(1, 8);
      else if (pick < 88) batch_len = $urandom_range(9, 30);
      else if (pick < 97) batch_len = $urandom_range(31, STORE_DEPTH);
      else batch_len = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 4);
      if (batch_len > RANDOM_ITEMS - sent) batch_len = RANDOM_ITEMS - sent;
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      for (i = 0; i < batch_len; i++) send_sample(random_sample(), i == batch_len - 1);
      sent += batch_len;
      if ($urandom_range(0, 4) == 0) wait_results_drained();
    end
  endtask

  always @(negedge clk) begin
    rx_tick <= rx_tick + 1'b1;
    if (hold_ticket != hold_seen) begin
      hold_seen = hold_ticket;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_STEADY: m_tready <= 1'b1;
        RX_COIN: m_tready <= 1'($urandom_range(0, 1));
        RX_PATTERN: m_tready <= RX_MASK[rx_tick];
        default: m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin : check_results
    sorted_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (sorted_expect.size() == 0) begin
        $error("unexpected transaction: sorted_value %0d", $signed(m_tdata));
        errors++;
      end else begin
        want = sorted_expect.pop_front();
        if (m_tdata !== want.value) begin
          $error("sorted_value: expected %0d, actual %0d", want.value, $signed(m_tdata));
          errors++;
        end
        if (m_tlast !== want.last) begin
          $error("end_of_run: expected %0b, actual %0b", want.last, m_tlast);
          errors++;
        end
        if (m_tuser !== want.ovf) begin
          $error("overflowed: expected %0b, actual %0b", want.ovf, m_tuser);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    test_single_item_batches();
    test_extreme_values();
    test_reverse_order();
    test_store_overflow();
    test_output_backpressure();
    test_random_batches();
    wait_results_drained();
    repeat (20) @(posedge clk);
    if (errors == 0 && sorted_expect.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
